// File: hw/rtl/srsc_pkg.sv
// Shared constants, types and angle helpers for the rudder and sail command core.
package srsc_pkg;

    localparam int HEAD_W  = 12;   // heading, tenths of degree
    localparam int ANGLE_W = 11;   // folded angle 0..1800
    localparam int POS_W   = 8;    // servo position
    localparam int HALF_W  = 7;    // rudder offset, at most 90
    localparam int ADDR_W  = 5;    // eight registers at 4-byte steps
    localparam int DATA_W  = 32;

    localparam logic [HEAD_W-1:0]  FULL_TURN  = 12'd3600;
    localparam logic [HEAD_W-1:0]  HALF_TURN  = 12'd1800;

    localparam logic [POS_W-1:0]   TRIM_CLOSE = 8'd220;
    localparam logic [POS_W-1:0]   TRIM_BEAM  = 8'd150;
    localparam logic [POS_W-1:0]   TRIM_BROAD = 8'd70;

    // err / 20 as (err * DIV20_MUL) >> DIV20_SHIFT, exact for err below 2048
    localparam int                 DIV20_SHIFT = 16;
    localparam logic [11:0]        DIV20_MUL   = 12'd3277;

    localparam logic [ANGLE_W-1:0] RST_DEAD_ANGLE  = 11'd450;
    localparam logic [POS_W-1:0]   RST_RUD_NEUTRAL = 8'd130;
    localparam logic [POS_W-1:0]   RST_RUD_MIN     = 8'd50;
    localparam logic [POS_W-1:0]   RST_RUD_MAX     = 8'd230;
    localparam logic [POS_W-1:0]   RST_SAIL_MIN    = 8'd80;
    localparam logic [POS_W-1:0]   RST_SAIL_MAX    = 8'd220;
    localparam logic [ANGLE_W-1:0] RST_CLOSE_LIM   = 11'd750;
    localparam logic [ANGLE_W-1:0] RST_BEAM_LIM    = 11'd1100;

    typedef enum logic [2:0] {
        REG_DEAD_ANGLE  = 3'd0,
        REG_RUD_NEUTRAL = 3'd1,
        REG_RUD_MIN     = 3'd2,
        REG_RUD_MAX     = 3'd3,
        REG_SAIL_MIN    = 3'd4,
        REG_SAIL_MAX    = 3'd5,
        REG_CLOSE_LIM   = 3'd6,
        REG_BEAM_LIM    = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic               side;
        logic [ANGLE_W-1:0] angle;
    } t_fold;

    // Headings 3600..4095 come back into range by one subtraction.
    function automatic logic [HEAD_W-1:0] norm_heading(input logic [HEAD_W-1:0] h);
        logic [HEAD_W-1:0] r;
        r = (h >= FULL_TURN) ? (h - FULL_TURN) : h;
        return r;
    endfunction

    // Folded angle from b to a; side is 1 when a lies clockwise of b.
    function automatic t_fold fold_angle(input logic [HEAD_W-1:0] a,
                                         input logic [HEAD_W-1:0] b);
        logic [HEAD_W-1:0] d;
        logic              s;
        logic [HEAD_W-1:0] f;
        t_fold             r;
        if (a > b) begin
            d = a - b;
            s = 1'b1;
        end else begin
            d = b - a;
            s = 1'b0;
        end
        if (d > HALF_TURN) begin
            f = FULL_TURN - d;
            s = ~s;
        end else begin
            f = d;
        end
        r.side  = s;
        r.angle = f[ANGLE_W-1:0];
        return r;
    endfunction

endpackage

// File: hw/rtl/sailboat_rudder_sail_command_core.sv
// Top level: rudder and sail servo command pipeline with APB register bank.
//
//  channel   | direction | handshake               | payload
//  ----------+-----------+-------------------------+---------------------------------
//  s_axis    | in        | tvalid / tready         | tdata[39:0] boat, target, wind
//  m_axis    | out       | tvalid / tready         | tdata[23:0] rudder, sail, flags
//  apb       | in        | psel, penable, pwrite   | paddr[4:0], pwdata, prdata
//
//  Three register stages (input, course, result): an accepted item passes
//  through all three before it shows on m_axis; one item can enter every
//  cycle while m_axis is not stalled. Folds and course forcing sit in the
//  first stage; error fold, rudder offset and the sail multiplier in the second.
//  Each stage moves on when the one after it is empty or moving, so a stalled
//  output only holds back the items behind it; bubbles still fill up.
//  Synchronous active-low reset clears stage valid bits and loads the register
//  defaults; the pipeline payload is not reset. pready is tied high.
module sailboat_rudder_sail_command_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // s_axis_tdata: boat_heading[11:0], target_heading[23:12],
    //               wind_direction[35:24], zero[39:36]
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [39:0]                    s_axis_tdata,
    // m_axis_tdata: rudder_position[7:0], sail_position[15:8],
    //               turn_right[16], tacking[17], zero[23:18]
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [23:0]                    m_axis_tdata,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [srsc_pkg::ADDR_W-1:0]    paddr,
    input  logic [srsc_pkg::DATA_W-1:0]    pwdata,
    output logic [srsc_pkg::DATA_W-1:0]    prdata,
    output logic                           pready
);
    import srsc_pkg::*;

    // ---------------- register bank ----------------
    logic [ANGLE_W-1:0] r_dead_angle;
    logic [POS_W-1:0]   r_rud_neutral;
    logic [POS_W-1:0]   r_rud_min;
    logic [POS_W-1:0]   r_rud_max;
    logic [POS_W-1:0]   r_sail_min;
    logic [POS_W-1:0]   r_sail_max;
    logic [ANGLE_W-1:0] r_close_lim;
    logic [ANGLE_W-1:0] r_beam_lim;

    logic     cfg_wr;
    t_reg_idx cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_angle  <= RST_DEAD_ANGLE;
            r_rud_neutral <= RST_RUD_NEUTRAL;
            r_rud_min     <= RST_RUD_MIN;
            r_rud_max     <= RST_RUD_MAX;
            r_sail_min    <= RST_SAIL_MIN;
            r_sail_max    <= RST_SAIL_MAX;
            r_close_lim   <= RST_CLOSE_LIM;
            r_beam_lim    <= RST_BEAM_LIM;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_DEAD_ANGLE:  r_dead_angle  <= pwdata[ANGLE_W-1:0];
                REG_RUD_NEUTRAL: r_rud_neutral <= pwdata[POS_W-1:0];
                REG_RUD_MIN:     r_rud_min     <= pwdata[POS_W-1:0];
                REG_RUD_MAX:     r_rud_max     <= pwdata[POS_W-1:0];
                REG_SAIL_MIN:    r_sail_min    <= pwdata[POS_W-1:0];
                REG_SAIL_MAX:    r_sail_max    <= pwdata[POS_W-1:0];
                REG_CLOSE_LIM:   r_close_lim   <= pwdata[ANGLE_W-1:0];
                REG_BEAM_LIM:    r_beam_lim    <= pwdata[ANGLE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            REG_DEAD_ANGLE:  prdata[ANGLE_W-1:0] = r_dead_angle;
            REG_RUD_NEUTRAL: prdata[POS_W-1:0]   = r_rud_neutral;
            REG_RUD_MIN:     prdata[POS_W-1:0]   = r_rud_min;
            REG_RUD_MAX:     prdata[POS_W-1:0]   = r_rud_max;
            REG_SAIL_MIN:    prdata[POS_W-1:0]   = r_sail_min;
            REG_SAIL_MAX:    prdata[POS_W-1:0]   = r_sail_max;
            REG_CLOSE_LIM:   prdata[ANGLE_W-1:0] = r_close_lim;
            REG_BEAM_LIM:    prdata[ANGLE_W-1:0] = r_beam_lim;
            default:         prdata = '0;
        endcase
    end

    // ---------------- stage flow control ----------------
    logic r_v1, r_v2, r_v3;
    logic en1, en2, en3;

    assign en3 = ~r_v3 | m_axis_tready;
    assign en2 = ~r_v2 | en3;
    assign en1 = ~r_v1 | en2;
    assign s_axis_tready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) r_v1 <= s_axis_tvalid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    // ---------------- input register ----------------
    logic [HEAD_W-1:0] r_boat, r_target, r_wind;

    always_ff @(posedge i_clk) begin
        if (en1 && s_axis_tvalid) begin
            r_boat   <= s_axis_tdata[11:0];
            r_target <= s_axis_tdata[23:12];
            r_wind   <= s_axis_tdata[35:24];
        end
    end

    // ---------------- stage A: wind fold, course, trim band ----------------
    logic [HEAD_W-1:0] boat_n, target_n, wind_n;
    t_fold             wt_fold;
    logic [HEAD_W:0]   course_up, course_dn;
    logic [HEAD_W-1:0] n_course;
    logic              n_tacking;
    logic [POS_W-1:0]  n_trim;

    assign boat_n   = norm_heading(r_boat);
    assign target_n = norm_heading(r_target);
    assign wind_n   = norm_heading(r_wind);
    assign wt_fold  = fold_angle(target_n, wind_n);

    assign course_up = {1'b0, wind_n} + {2'b00, r_dead_angle};
    assign course_dn = {1'b0, wind_n} - {2'b00, r_dead_angle};

    always_comb begin
        n_tacking = (wt_fold.angle < r_dead_angle);
        if (!n_tacking) begin
            n_course = target_n;
        end else if (wt_fold.side) begin
            // one wrap is enough: wind below 3600, dead angle below 2048
            n_course = (course_up >= {1'b0, FULL_TURN}) ?
                       12'(course_up - {1'b0, FULL_TURN}) : course_up[HEAD_W-1:0];
        end else begin
            n_course = course_dn[HEAD_W] ?
                       12'(course_dn + {1'b0, FULL_TURN}) : course_dn[HEAD_W-1:0];
        end

        // first test wins when the limits are inverted
        if (wt_fold.angle < r_close_lim)
            n_trim = TRIM_CLOSE;
        else if (wt_fold.angle <= r_beam_lim)
            n_trim = TRIM_BEAM;
        else
            n_trim = TRIM_BROAD;
    end

    logic [HEAD_W-1:0] r_boat_a, r_course;
    logic              r_tacking_a;
    logic [POS_W-1:0]  r_trim;

    always_ff @(posedge i_clk) begin
        if (en2 && r_v1) begin
            r_boat_a    <= boat_n;
            r_course    <= n_course;
            r_tacking_a <= n_tacking;
            r_trim      <= n_trim;
        end
    end

    // ---------------- stage B: heading error, rudder, sail ----------------
    t_fold                      err_fold;
    logic [ANGLE_W+11:0]        half_prod;
    logic [HALF_W-1:0]          half;
    logic [POS_W:0]             rud_up, rud_dn;
    logic [POS_W-1:0]           n_rudder;

    assign err_fold  = fold_angle(r_course, r_boat_a);
    // floor(floor(err/10)/2) == floor(err/20)
    assign half_prod = err_fold.angle * DIV20_MUL;
    assign half      = half_prod[DIV20_SHIFT +: HALF_W];

    assign rud_up = {1'b0, r_rud_neutral} + {2'b00, half};
    assign rud_dn = {1'b0, r_rud_neutral} - {2'b00, half};

    always_comb begin
        if (err_fold.side) begin
            n_rudder = (rud_up > {1'b0, r_rud_max}) ? r_rud_max : rud_up[POS_W-1:0];
        end else begin
            n_rudder = ($signed(rud_dn) < $signed({1'b0, r_rud_min})) ?
                       r_rud_min : rud_dn[POS_W-1:0];
        end
    end

    // sail_min + (sail_max - sail_min) * trim / 256, truncated toward zero
    logic signed [POS_W:0]     sail_span;
    logic signed [2*POS_W+1:0] sail_prod;
    logic signed [2*POS_W+1:0] sail_adj;
    logic signed [POS_W+1:0]   sail_q;
    logic signed [POS_W+1:0]   sail_sum;
    logic [POS_W-1:0]          n_sail;

    assign sail_span = $signed({1'b0, r_sail_max}) - $signed({1'b0, r_sail_min});
    assign sail_prod = sail_span * $signed({1'b0, r_trim});
    assign sail_adj  = sail_prod[2*POS_W+1] ? (sail_prod + 18'sd255) : sail_prod;
    assign sail_q    = sail_adj[2*POS_W+1:POS_W];
    assign sail_sum  = sail_q + $signed({2'b00, r_sail_min});

    always_comb begin
        if (sail_sum[POS_W+1])
            n_sail = '0;
        else if (sail_sum[POS_W])
            n_sail = 8'hFF;
        else
            n_sail = sail_sum[POS_W-1:0];
    end

    // ---------------- result register ----------------
    logic [POS_W-1:0] r_rudder, r_sail;
    logic             r_right, r_tacking;

    always_ff @(posedge i_clk) begin
        if (en3 && r_v2) begin
            r_rudder  <= n_rudder;
            r_sail    <= n_sail;
            r_right   <= err_fold.side;
            r_tacking <= r_tacking_a;
        end
    end

    assign m_axis_tvalid = r_v3;
    assign m_axis_tdata  = {6'b0, r_tacking, r_right, r_sail, r_rudder};

endmodule

// File: test/sailboat_rudder_sail_command_core_test.sv
// Self-checking stream testbench for the rudder and sail command core.
`timescale 1ns / 1ps

module sailboat_rudder_sail_command_core_test;
    import srsc_pkg::*;

    localparam int PHASES          = 12;   // register settings after the directed part
    localparam int ITEMS_PER_PHASE = 119;
    localparam int HOLD_CYCLES     = 150;  // long output back-pressure stretch
    localparam int TAIL_CYCLES     = 8;    // pipeline is three stages deep
    localparam int STALL_LIMIT     = 4000; // cycles with no handshake before giving up

    // One servo command as it leaves the block.
    typedef struct packed {
        logic [POS_W-1:0] rudder;
        logic [POS_W-1:0] sail;
        logic             right;
        logic             tacking;
    } servo_cmd_t;

    // Holds the register shadow and the commands still owed by the block.
    class servo_cmd_tracker;
        int unsigned reg_val[8];
        servo_cmd_t  pending_cmds[$];
        int unsigned failures;

        function new();
            reg_val[REG_DEAD_ANGLE]  = RST_DEAD_ANGLE;
            reg_val[REG_RUD_NEUTRAL] = RST_RUD_NEUTRAL;
            reg_val[REG_RUD_MIN]     = RST_RUD_MIN;
            reg_val[REG_RUD_MAX]     = RST_RUD_MAX;
            reg_val[REG_SAIL_MIN]    = RST_SAIL_MIN;
            reg_val[REG_SAIL_MAX]    = RST_SAIL_MAX;
            reg_val[REG_CLOSE_LIM]   = RST_CLOSE_LIM;
            reg_val[REG_BEAM_LIM]    = RST_BEAM_LIM;
            failures = 0;
        endfunction

        function void set_reg(input t_reg_idx idx, input int unsigned v);
            if (idx == REG_DEAD_ANGLE || idx == REG_CLOSE_LIM || idx == REG_BEAM_LIM)
                reg_val[idx] = v & 32'h7FF;
            else
                reg_val[idx] = v & 32'hFF;
        endfunction

        function int pending();
            return pending_cmds.size();
        endfunction

        // Shortest angle from b to a; side set when a is clockwise of b.
        static function int swing(input int a, input int b, output bit side);
            int d;
            if (a > b) begin
                d    = a - b;
                side = 1'b1;
            end else begin
                d    = b - a;
                side = 1'b0;
            end
            if (d > int'(HALF_TURN)) begin
                d    = int'(FULL_TURN) - d;
                side = ~side;
            end
            return d;
        endfunction

        function servo_cmd_t servo_cmd_for(input logic [HEAD_W-1:0] b_raw,
                                           input logic [HEAD_W-1:0] t_raw,
                                           input logic [HEAD_W-1:0] w_raw);
            int         boat, tgt, wind, off_wind, course, err, half, rud, trim, sail;
            bit         wind_side, right;
            servo_cmd_t cmd;
            boat = (b_raw >= FULL_TURN) ? int'(b_raw) - int'(FULL_TURN) : int'(b_raw);
            tgt  = (t_raw >= FULL_TURN) ? int'(t_raw) - int'(FULL_TURN) : int'(t_raw);
            wind = (w_raw >= FULL_TURN) ? int'(w_raw) - int'(FULL_TURN) : int'(w_raw);

            off_wind    = swing(tgt, wind, wind_side);
            cmd.tacking = (off_wind < int'(reg_val[REG_DEAD_ANGLE]));
            if (cmd.tacking) begin
                // beat to the edge of the no-go zone on the target's side
                if (wind_side) begin
                    course = wind + int'(reg_val[REG_DEAD_ANGLE]);
                    if (course >= int'(FULL_TURN))
                        course -= int'(FULL_TURN);
                end else begin
                    course = wind - int'(reg_val[REG_DEAD_ANGLE]);
                    if (course < 0)
                        course += int'(FULL_TURN);
                end
            end else begin
                course = tgt;
            end

            err  = swing(course, boat, right);
            half = (err / 10) / 2;
            if (right) begin
                rud = int'(reg_val[REG_RUD_NEUTRAL]) + half;
                if (rud > int'(reg_val[REG_RUD_MAX]))
                    rud = int'(reg_val[REG_RUD_MAX]);
            end else begin
                rud = int'(reg_val[REG_RUD_NEUTRAL]) - half;
                if (rud < int'(reg_val[REG_RUD_MIN]))
                    rud = int'(reg_val[REG_RUD_MIN]);
            end

            if (off_wind < int'(reg_val[REG_CLOSE_LIM]))
                trim = int'(TRIM_CLOSE);
            else if (off_wind <= int'(reg_val[REG_BEAM_LIM]))
                trim = int'(TRIM_BEAM);
            else
                trim = int'(TRIM_BROAD);
            sail = ((int'(reg_val[REG_SAIL_MAX]) - int'(reg_val[REG_SAIL_MIN])) * trim) / 256
                   + int'(reg_val[REG_SAIL_MIN]);
            if (sail > 255)
                sail = 255;
            if (sail < 0)
                sail = 0;

            cmd.rudder = POS_W'(rud);
            cmd.sail   = POS_W'(sail);
            cmd.right  = right;
            return cmd;
        endfunction

        function void note_headings(input logic [39:0] d);
            pending_cmds.push_back(servo_cmd_for(d[11:0], d[23:12], d[35:24]));
        endfunction

        function void check_command(input logic [23:0] d);
            servo_cmd_t want;
            if (pending_cmds.size() == 0) begin
                $error("command %h with none pending", d);
                failures++;
                return;
            end
            want = pending_cmds.pop_front();
            if (d[7:0] !== want.rudder) begin
                $error("rudder_position: expected %0d, got %0d", want.rudder, d[7:0]);
                failures++;
            end
            if (d[15:8] !== want.sail) begin
                $error("sail_position: expected %0d, got %0d", want.sail, d[15:8]);
                failures++;
            end
            if (d[16] !== want.right) begin
                $error("turn_right: expected %0b, got %0b", want.right, d[16]);
                failures++;
            end
            if (d[17] !== want.tacking) begin
                $error("tacking: expected %0b, got %0b", want.tacking, d[17]);
                failures++;
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    // boat_heading[11:0], target_heading[23:12], wind_direction[35:24], zero[39:36]
    logic [39:0]         s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    // rudder_position[7:0], sail_position[15:8], turn_right[16], tacking[17], zero[23:18]
    logic [23:0]         m_axis_tdata;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    servo_cmd_tracker    sb;
    bit                  no_gaps;       // both sides run flat out while set
    bit                  hold_request;  // asks the receiver for one long stall
    int unsigned         stall_cycles;

    sailboat_rudder_sail_command_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Handshakes are sampled at the edge, ahead of any driver update in that step.
    // Inputs are noted before results are checked; an item passes the input, course
    // and result registers on its way out, so the order here never matters anyway.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_cycles = 0;
        end else begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (s_axis_tvalid && s_axis_tready)
                sb.note_headings(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_command(m_axis_tdata);
            if (stall_cycles >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Receiver: a random wait before each item, or a long hold when asked.
    initial begin
        int unsigned pause;
        m_axis_tready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_request) begin
                // keep the output blocked so the pipeline fills and backs up
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
            end
            pause = no_gaps ? 0 : $urandom_range(0, 7);
            if (pause != 0) begin
                m_axis_tready <= 1'b0;
                repeat (pause) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    // Offers one heading triple after a random gap and holds it until taken.
    task automatic send_headings(input logic [HEAD_W-1:0] boat,
                                 input logic [HEAD_W-1:0] tgt,
                                 input logic [HEAD_W-1:0] wind);
        int unsigned gap;
        gap = no_gaps ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, wind, tgt, boat};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Sender stops and waits until every owed command has come back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // Writes all eight registers back to back; psel stays up between them.
    task automatic write_settings(input int unsigned vals[8]);
        for (int k = 0; k < 8; k++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= ADDR_W'(k << 2);
            pwdata  <= vals[k];
            @(posedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
            sb.set_reg(t_reg_idx'(k), vals[k]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Heading offset from base by off tenths, either way round, wrapped.
    function automatic int offset_heading(input int base, input int off);
        if ($urandom_range(0, 1))
            return (base + off) % 3600;
        return (base + 7200 - off) % 3600;
    endfunction

    task automatic send_random_item();
        int kind, boat, tgt, wind, off;
        kind = $urandom_range(0, 9);
        boat = $urandom_range(0, 4095);
        tgt  = $urandom_range(0, 4095);
        wind = $urandom_range(0, 4095);
        if (kind == 5 || kind == 6) begin
            // target close to the no-go edge, both inside and just outside
            wind = $urandom_range(0, 3599);
            off  = $urandom_range(0, sb.reg_val[REG_DEAD_ANGLE] + 2);
            tgt  = offset_heading(wind, off);
        end else if (kind == 7) begin
            // target right on a sail band boundary
            wind = $urandom_range(0, 3599);
            off  = $urandom_range(0, 1) ? sb.reg_val[REG_CLOSE_LIM] : sb.reg_val[REG_BEAM_LIM];
            off  = off + $urandom_range(0, 2) - 1;
            if (off < 0)
                off = 0;
            tgt  = offset_heading(wind, off);
        end else if (kind == 8) begin
            // boat nearly on target: small errors around the rudder step
            tgt  = $urandom_range(0, 3599);
            boat = offset_heading(tgt, $urandom_range(0, 40));
        end else if (kind == 9) begin
            boat = $urandom_range(0, 3599);
            tgt  = $urandom_range(0, 3599);
            wind = $urandom_range(0, 3599);
        end
        send_headings(HEAD_W'(boat), HEAD_W'(tgt), HEAD_W'(wind));
    endtask

    initial begin
        int unsigned cfg[8];
        sb = new();
        no_gaps      = 1'b0;
        hold_request = 1'b0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, reset register values:
        // dead angle 450, close reach below 750, beam reach up to 1100.
        send_headings(12'd0,    12'd0,    12'd0);     // target on wind, wrap below zero
        send_headings(12'd4095, 12'd4095, 12'd4095);  // all bits set, out of range
        send_headings(12'd3599, 12'd3599, 12'd0);     // fold across north, left tack
        send_headings(12'd1800, 12'd50,   12'd3550);  // right tack, course wraps past 3600
        send_headings(12'd0,    12'd1800, 12'd0);     // exactly half a turn, full right
        send_headings(12'd0,    12'd1801, 12'd0);     // just past half a turn, side flips
        send_headings(12'd100,  12'd1000, 12'd550);   // on the no-go edge, not forced
        send_headings(12'd100,  12'd999,  12'd550);   // one inside the no-go edge
        send_headings(12'd0,    12'd1300, 12'd550);   // on the close reach limit
        send_headings(12'd0,    12'd1299, 12'd550);   // just below it
        send_headings(12'd0,    12'd1650, 12'd550);   // on the beam reach limit
        send_headings(12'd0,    12'd1651, 12'd550);   // just above it, broad reach
        send_headings(12'd3000, 12'd1200, 12'd0);     // full left, clamps at rudder_min
        send_headings(12'd2000, 12'd1200, 12'd0);     // mid left
        send_headings(12'd1200, 12'd1219, 12'd0);     // error below one rudder step
        send_headings(12'd1200, 12'd1220, 12'd0);     // error of one rudder step
        send_headings(12'd3600, 12'd0,    12'd3600);  // 3600 taken as north
        send_headings(12'd1234, 12'd3700, 12'd100);   // out of range target on wind
        send_headings(12'd2500, 12'd3599, 12'd3599);
        send_headings(12'h555,  12'hAAA,  12'h555);   // alternating bit patterns
        send_headings(12'hAAA,  12'h555,  12'hAAA);

        for (int phase = 1; phase <= PHASES; phase++) begin
            drain();
            case (phase)
                1: cfg = '{2047, 255, 255, 255, 255, 255, 2047, 2047};
                2: cfg = '{0, 0, 0, 0, 0, 0, 0, 0};
                // sail limits swapped, reach limits inverted
                3: cfg = '{1800, 0, 0, 255, 255, 0, 1800, 0};
                4: cfg = '{RST_DEAD_ANGLE, RST_RUD_NEUTRAL, RST_RUD_MIN, RST_RUD_MAX,
                           RST_SAIL_MIN, RST_SAIL_MAX, RST_CLOSE_LIM, RST_BEAM_LIM};
                default: begin
                    cfg[REG_DEAD_ANGLE]  = $urandom_range(0, 1) ? $urandom_range(0, 2047)
                                                                : $urandom_range(100, 900);
                    cfg[REG_RUD_NEUTRAL] = $urandom_range(0, 255);
                    cfg[REG_RUD_MIN]     = $urandom_range(0, 255);
                    cfg[REG_RUD_MAX]     = $urandom_range(0, 255);
                    cfg[REG_SAIL_MIN]    = $urandom_range(0, 255);
                    cfg[REG_SAIL_MAX]    = $urandom_range(0, 255);
                    cfg[REG_CLOSE_LIM]   = $urandom_range(0, 2047);
                    cfg[REG_BEAM_LIM]    = $urandom_range(0, 2047);
                end
            endcase
            write_settings(cfg);
            no_gaps = (phase % 4 == 2);
            // one phase starts under a long output stall while the sender keeps going
            if (phase == 6)
                hold_request = 1'b1;
            repeat (ITEMS_PER_PHASE) send_random_item();
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
